>>> rtl/orol_pkg.sv
package orol_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int SIZE_BITS_DEFAULT = 16;

  // Field widths fixed by the interface
  localparam int HANDLE_W = 32;
  localparam int ESIZE_W  = 16;
  localparam int OFFS_W   = 20;
  localparam int SLOT_W   = 4;
  localparam int BOFF_W   = 16;

  localparam int IN_DATA_W  = 72;  // 68 bits of fields, padded to bytes
  localparam int OUT_DATA_W = 56;  // 53 bits of fields, padded to bytes

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_FIND = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic do_add;
    logic start_find;
    logic step;
    logic hit;
    logic miss;
    logic load_out;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/orol_ctrl.sv
module orol_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  input  logic            s_axis_tuser,
  output logic            s_axis_tready,
  input  orol_pkg::stat_t stat,
  output orol_pkg::cmd_t  cmd
);

  orol_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= orol_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      orol_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == orol_pkg::REQ_ADD) begin
            cmd.do_add = 1'b1;
            state_next = orol_pkg::ST_EMIT;
          end else begin
            cmd.start_find = 1'b1;
            state_next     = orol_pkg::ST_WALK;
          end
        end
      end
      orol_pkg::ST_WALK: begin
        if (stat.cnt_zero) begin
          cmd.miss   = 1'b1;
          state_next = orol_pkg::ST_EMIT;
        end else if (stat.hit) begin
          cmd.hit    = 1'b1;
          state_next = orol_pkg::ST_EMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      orol_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = orol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = orol_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/orol_dp.sv
module orol_dp #(
  parameter int DEPTH     = orol_pkg::DEPTH_DEFAULT,
  parameter int SIZE_BITS = orol_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [orol_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  orol_pkg::cmd_t                  cmd,
  output orol_pkg::stat_t                 stat,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [orol_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser
);

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int SW   = SIZE_BITS;
  localparam int RW   = orol_pkg::OFFS_W;
  localparam int CW   = (SW > RW) ? SW : RW;
  localparam int HW   = orol_pkg::HANDLE_W;
  localparam int MW   = HW + SW;

  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  // Request fields
  logic [HW-1:0]                 in_handle;
  logic [orol_pkg::ESIZE_W-1:0]  in_esize;
  logic [RW-1:0]                 in_offs;
  logic [SW+orol_pkg::ESIZE_W-1:0] esize_ext;
  logic [SW-1:0]                 in_size;

  assign in_handle = s_axis_tdata[HW-1:0];
  assign in_esize  = s_axis_tdata[HW+orol_pkg::ESIZE_W-1:HW];
  assign in_offs   = s_axis_tdata[HW+orol_pkg::ESIZE_W+RW-1:HW+orol_pkg::ESIZE_W];
  assign esize_ext = {{SW{1'b0}}, in_esize};
  assign in_size   = esize_ext[SW-1:0];

  // Ring pointers
  logic [IW-1:0] wr_idx, oldest;
  logic          full;
  logic [IW-1:0] wr_idx_next, oldest_next;

  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
    nxt = (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  assign wr_idx_next = nxt(wr_idx);
  assign oldest_next = full ? nxt(oldest) : oldest;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      oldest <= '0;
      full   <= 1'b0;
    end else if (cmd.do_add) begin
      wr_idx <= wr_idx_next;
      oldest <= oldest_next;
      if (wr_idx_next == oldest_next) begin
        full <= 1'b1;
      end
    end
  end

  // Slot store: {handle, size}. The walk only visits slots that were written
  // since reset, so the walk never uses an unwritten entry.
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] cur;

  assign rd_addr = cmd.start_find ? oldest : nxt(cur);

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      mem[wr_idx] <= {in_handle, in_size};
    end
    rd_data <= mem[rd_addr];
  end

  // Walk state
  logic [RW-1:0]   remain;
  logic [CNTW-1:0] cnt;
  logic [IW:0]     span;
  logic [CNTW-1:0] cnt_init;
  logic [SW-1:0]   rd_size;
  logic [CW-1:0]   rem_ext, size_ext, rem_diff;

  assign span = (wr_idx >= oldest) ? ({1'b0, wr_idx} - {1'b0, oldest})
              : ({1'b0, wr_idx} + (IW+1)'(DEPTH) - {1'b0, oldest});
  assign cnt_init = full ? CNTW'(DEPTH) : span[CNTW-1:0];

  assign rd_size  = rd_data[SW-1:0];
  assign rem_ext  = CW'(remain);
  assign size_ext = CW'(rd_size);
  assign rem_diff = rem_ext - size_ext;

  always_ff @(posedge clk) begin
    if (cmd.start_find) begin
      remain <= in_offs;
      cur    <= oldest;
    end else if (cmd.step) begin
      remain <= rem_diff[RW-1:0];
      cur    <= nxt(cur);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.start_find) begin
      cnt <= cnt_init;
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Result register
  logic                        res_found;
  logic [IW-1:0]               res_idx;
  logic [HW-1:0]               res_handle;
  logic [orol_pkg::BOFF_W-1:0] res_boff;
  logic [IW+orol_pkg::SLOT_W-1:0] idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_found <= 1'b0;
    end else if (cmd.do_add || cmd.miss) begin
      res_found <= 1'b0;
    end else if (cmd.hit) begin
      res_found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      res_idx    <= wr_idx;
      res_handle <= '0;
      res_boff   <= '0;
    end else if (cmd.miss) begin
      res_idx    <= '0;
      res_handle <= '0;
      res_boff   <= '0;
    end else if (cmd.hit) begin
      res_idx    <= cur;
      res_handle <= rd_data[MW-1:SW];
      res_boff   <= remain[orol_pkg::BOFF_W-1:0];
    end
  end

  assign idx_ext = {{orol_pkg::SLOT_W{1'b0}}, res_idx};

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_axis_tuser <= res_found;
      m_axis_tdata <= {3'b000, full, res_boff, res_handle,
                       idx_ext[orol_pkg::SLOT_W-1:0]};
    end
  end

  assign stat.cnt_zero = (cnt == '0);
  assign stat.hit      = (rem_ext < size_ext);
  assign stat.out_free = !m_axis_tvalid || m_axis_tready;

  // Once full, the ring never drains: there is no remove request.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("full flag dropped");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    full |-> (wr_idx == oldest))
    else $error("full ring with split pointers");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNTW'(DEPTH))
    else $error("walk count beyond ring depth");

  a_hit_found: assert property (@(posedge clk) disable iff (rst)
    cmd.hit |=> res_found)
    else $error("hit not recorded");

endmodule

>>> rtl/overwriting_ring_offset_lookup_top.sv
// Overwriting ring of (handle, size) records with a character-offset lookup.
//
// Requests come in on the s_axis channel; tuser selects add (0) or find (1).
// Add stores the record at the write slot, dropping the oldest one when the
// ring is full. Find walks the stored sizes from the oldest slot, one slot per
// cycle, until the offset falls inside a slot or the stored data runs out.
// Exactly one result per request leaves on m_axis; tuser carries found.
//
// From accept to result, add records its slot in the result register and
// then loads the output register; find first walks the slots, stopping at
// the hit, or after every stored slot on a miss, and then does the same.
// Throughput is one request at a time; the walk over the slot memory, one
// registered read per cycle, sets the find time.
// The output register holds a finished result while the receiver stalls;
// the next request may be accepted meanwhile, and its result waits in the
// datapath until the output register frees up.
// Reset clears the ring pointers, the full flag and the output valid. The
// ring is empty after reset, so no clearing pass over the slot store runs.
module overwriting_ring_offset_lookup_top #(
  parameter int DEPTH     = orol_pkg::DEPTH_DEFAULT,
  parameter int SIZE_BITS = orol_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] entry_handle, [47:32] entry_size, [67:48] stream_pos, rest zero
  input  logic [orol_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] slot_index, [35:4] found_handle, [51:36] byte_offset,
  // [52] ring_full, rest zero
  output logic [orol_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] found
  output logic                            m_axis_tuser
);

  orol_pkg::cmd_t  cmd;
  orol_pkg::stat_t stat;

  // Sequencer: accept, walk, hand off to the output register
  orol_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Ring pointers, slot memory, walk registers and output register
  orol_dp #(
    .DEPTH     (DEPTH),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> tb/overwriting_ring_offset_lookup_top_tb.sv
module overwriting_ring_offset_lookup_top_tb;

  localparam int RING_SLOTS = orol_pkg::DEPTH_DEFAULT;

  // One request as the sender sees it
  typedef struct packed {
    orol_pkg::req_t                kind;
    logic [orol_pkg::HANDLE_W-1:0] handle;
    logic [orol_pkg::ESIZE_W-1:0]  size;
    logic [orol_pkg::OFFS_W-1:0]   offset;
  } ring_req_t;

  // One result as it leaves on m_axis
  typedef struct packed {
    logic                          found;
    logic [orol_pkg::SLOT_W-1:0]   slot;
    logic [orol_pkg::HANDLE_W-1:0] handle;
    logic [orol_pkg::BOFF_W-1:0]   boff;
    logic                          full;
  } ring_rsp_t;

  // Mirror of the ring plus the queue of results still owed by the block.
  class ring_lookup_checker;
    logic [orol_pkg::ESIZE_W-1:0]  sizes   [RING_SLOTS];
    logic [orol_pkg::HANDLE_W-1:0] handles [RING_SLOTS];
    int unsigned wr_slot;
    int unsigned old_slot;
    bit          full;
    ring_rsp_t   expected_lookups[$];
    int          errors;
    int          results;

    function new();
      foreach (sizes[i]) begin
        sizes[i]   = '0;
        handles[i] = '0;
      end
      wr_slot  = 0;
      old_slot = 0;
      full     = 1'b0;
      errors   = 0;
      results  = 0;
    endfunction

    function int unsigned live_slots();
      return full ? RING_SLOTS : (wr_slot + RING_SLOTS - old_slot) % RING_SLOTS;
    endfunction

    // Total bytes of the concatenated stream, oldest to newest
    function int unsigned stored_bytes();
      int unsigned total;
      total = 0;
      for (int k = 0; k < live_slots(); k++)
        total += sizes[(old_slot + k) % RING_SLOTS];
      return total;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // Update the ring for an accepted request and queue its result
    function void note_request(ring_req_t r);
      ring_rsp_t   exp;
      int unsigned cur;
      int unsigned remain;
      int unsigned walk;
      exp = '0;
      if (r.kind == orol_pkg::REQ_ADD) begin
        if (full) old_slot = (old_slot + 1) % RING_SLOTS;
        handles[wr_slot] = r.handle;
        sizes[wr_slot]   = r.size;
        exp.slot = wr_slot[orol_pkg::SLOT_W-1:0];
        wr_slot  = (wr_slot + 1) % RING_SLOTS;
        if (wr_slot == old_slot) full = 1'b1;
      end else begin
        walk   = live_slots();
        cur    = old_slot;
        remain = r.offset;
        // zero-size slots never satisfy remain < size, so they get skipped
        for (int k = 0; k < walk; k++) begin
          if (remain < sizes[cur]) begin
            exp.found  = 1'b1;
            exp.slot   = cur[orol_pkg::SLOT_W-1:0];
            exp.handle = handles[cur];
            exp.boff   = remain[orol_pkg::BOFF_W-1:0];
            break;
          end
          remain -= sizes[cur];
          cur = (cur + 1) % RING_SLOTS;
        end
      end
      exp.full = full;
      expected_lookups.push_back(exp);
    endfunction

    function void check_result(ring_rsp_t got);
      ring_rsp_t exp;
      results++;
      if (expected_lookups.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: found=%0d slot=%0d handle=%h boff=%0d full=%0d",
                   got.found, got.slot, got.handle, got.boff, got.full);
        errors++;
        return;
      end
      exp = expected_lookups.pop_front();
      if (got !== exp) begin
        if (errors < 10) begin
          $display("result %0d mismatch: exp found=%0d slot=%0d handle=%h boff=%0d full=%0d",
                   results, exp.found, exp.slot, exp.handle, exp.boff, exp.full);
          $display("  got found=%0d slot=%0d handle=%h boff=%0d full=%0d",
                   got.found, got.slot, got.handle, got.boff, got.full);
        end
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [orol_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [orol_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  ring_lookup_checker board;
  bit                 hold_done = 1'b0;

  overwriting_ring_offset_lookup_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Small sizes keep finds landing inside the stream; extremes mixed in
  function automatic logic [orol_pkg::ESIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return orol_pkg::ESIZE_W'($urandom_range(1, 64));
    if (r < 70) return '0;
    if (r < 80) return '1;
    return orol_pkg::ESIZE_W'($urandom);
  endfunction

  function automatic logic [orol_pkg::OFFS_W-1:0] pick_offset(int unsigned total);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && total > 0) return orol_pkg::OFFS_W'($urandom_range(0, total - 1));
    if (r < 80) return total[orol_pkg::OFFS_W-1:0];  // first byte past the data
    if (r < 90) return '1;
    return orol_pkg::OFFS_W'($urandom);
  endfunction

  // Offer one request, wait for the handshake, then maybe idle
  task automatic drive_request(ring_req_t r);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {4'b0, r.offset, r.size, r.handle};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_request(r);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Fields a request ignores still carry random bits
  task automatic do_add(logic [orol_pkg::HANDLE_W-1:0] h,
                        logic [orol_pkg::ESIZE_W-1:0] sz);
    ring_req_t r;
    r.kind   = orol_pkg::REQ_ADD;
    r.handle = h;
    r.size   = sz;
    r.offset = orol_pkg::OFFS_W'($urandom);
    drive_request(r);
  endtask

  task automatic do_find(logic [orol_pkg::OFFS_W-1:0] off);
    ring_req_t r;
    r.kind   = orol_pkg::REQ_FIND;
    r.handle = $urandom;
    r.size   = orol_pkg::ESIZE_W'($urandom);
    r.offset = off;
    drive_request(r);
  endtask

  // Result monitor: values seen here are the ones before this edge
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      board.check_result('{found:  m_axis_tuser,
                           slot:   m_axis_tdata[3:0],
                           handle: m_axis_tdata[35:4],
                           boff:   m_axis_tdata[51:36],
                           full:   m_axis_tdata[52]});
  end

  // Receiver: bursts of ready with random stalls, plus one long hold-off
  // that backs the block up while the sender keeps offering requests.
  initial begin
    int run;
    m_axis_tready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (!hold_done && board.results >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(1, 20);
        repeat (run) @(posedge clk);
      end else begin
        run = pick_gap();
        m_axis_tready <= (run == 0);
        repeat (run == 0 ? 1 : run) @(posedge clk);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    board         = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: nothing can be found
    do_find('0);
    do_find('1);
    // zero-size record, then the handle and size extremes
    do_add('0, '0);
    do_add('1, '1);
    do_add($urandom, 16'd1);
    do_find('0);            // skips the empty slot, lands at byte 0 of slot 1
    do_find(20'd65534);     // last byte of the big record
    do_find(20'd65535);     // the one-byte record
    do_find(20'd65536);     // just past the data
    // fill the ring, then overwrite the oldest (the zero-size one)
    for (int i = 0; i < RING_SLOTS - 3; i++) do_add($urandom, '1);
    do_add(32'h5A5A_A5A5, '1);
    do_find(20'd983025);    // very last byte, newest slot
    do_find('1);

    for (int n = 0; n < 1450; n++) begin
      if ($urandom_range(0, 1) == 0)
        do_add($urandom, pick_size());
      else
        do_find(pick_offset(board.stored_bytes()));
    end
    s_axis_tvalid <= 1'b0;

    // drain, then leave room for any stray result
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> overwriting_ring_offset_lookup_top.f
rtl/orol_pkg.sv
rtl/orol_ctrl.sv
rtl/orol_dp.sv
rtl/overwriting_ring_offset_lookup_top.sv
tb/overwriting_ring_offset_lookup_top_tb.sv
